@@ rtl/core/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants of the point-triangle distance unit
// Widths of every pipeline stage, region codes and register indexes.
// ----------------------------------------------------------------------------
package ptd_pkg;

   // coordinate format
   localparam int CW        = 20;             // coordinate width
   localparam int DIF_W     = CW + 1;         // coordinate difference
   localparam int PROD_W    = 2 * DIF_W;      // one coordinate product
   localparam int DOT_W     = PROD_W + 4;     // 3-term dot product, with margin
   localparam int EW        = DOT_W + 1;      // difference of two dot products
   localparam int E2W       = DOT_W + 2;      // sum of two such differences
   localparam int NDOT      = 9;              // six projections, three squares

   // wide multiplier: A operand, B operand, product, chunking
   localparam int CHUNK     = 24;
   localparam int MA_W      = 96;
   localparam int MB_W      = 48;
   localparam int MP_W      = MA_W + MB_W;
   localparam int MUL_NA    = MA_W / CHUNK;
   localparam int MUL_NB    = MB_W / CHUNK;
   localparam int PP_W      = 2 * CHUNK + 2;
   localparam int MUL_LAT   = 3;

   // divider and square root
   localparam int QW        = 42;             // squared distance bits
   localparam int RW        = MA_W;           // remainder / denominator
   localparam int NUM_W     = RW + QW;        // numerator bits used
   localparam int ROOT_W    = QW / 2;
   localparam int SR_W      = ROOT_W + 4;
   localparam int DIST_W    = 21;

   // configuration port
   localparam int NUM_CORNERS = 3;
   localparam int CSR_W       = NUM_CORNERS * CW;
   localparam int CSR_IDX_W   = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_ONE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_TWO   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_THREE = 2'd2;

   // nearest feature
   typedef enum logic [2:0] {
      RGN_CORNER_A = 3'd0,
      RGN_CORNER_B = 3'd1,
      RGN_CORNER_C = 3'd2,
      RGN_EDGE_AB  = 3'd3,
      RGN_EDGE_AC  = 3'd4,
      RGN_EDGE_BC  = 3'd5,
      RGN_FACE     = 3'd6,
      RGN_DEGEN    = 3'd7
   } region_type;

endpackage

@@ rtl/core/ptd_if.sv @@
// ----------------------------------------------------------------------------
// ptd_req_if / ptd_rsp_if: request and response channels
// Valid/ready channels carrying a query point and a distance result.
// ----------------------------------------------------------------------------
interface ptd_req_if import ptd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] query_x;
   logic signed [CW-1:0] query_y;
   logic signed [CW-1:0] query_z;

   modport source (output valid, query_x, query_y, query_z, input ready);
   modport sink   (input valid, query_x, query_y, query_z, output ready);
endinterface

interface ptd_rsp_if import ptd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic [2:0]        nearest_region;

   modport source (output valid, distance, nearest_region, input ready);
   modport sink   (input valid, distance, nearest_region, output ready);
endinterface

@@ rtl/core/ptd_mul.sv @@
// ----------------------------------------------------------------------------
// ptd_mul: pipelined signed 96x48 multiplier
// 24-bit chunk partial products, two half sums, final add, each registered.
// ----------------------------------------------------------------------------
module ptd_mul import ptd_pkg::*; (
   input  logic                   clock,
   input  logic                   adv,
   input  logic signed [MA_W-1:0] a,
   input  logic signed [MB_W-1:0] b,
   output logic signed [MP_W-1:0] p
);

   logic signed [CHUNK:0]    ach [MUL_NA];
   logic signed [CHUNK:0]    bch [MUL_NB];
   logic signed [PP_W-1:0]   pp_in [MUL_NA][MUL_NB];
   logic signed [PP_W-1:0]   pp_ff [MUL_NA][MUL_NB];
   logic signed [MP_W-1:0]   lo_in, hi_in, lo_ff, hi_ff, p_ff;

   // chunks: lower ones unsigned, top one carries the sign
   always_comb begin
      for (int i = 0; i < MUL_NA; i++) begin
         if (i == MUL_NA - 1) ach[i] = {a[MA_W-1], a[i*CHUNK +: CHUNK]};
         else                 ach[i] = {1'b0, a[i*CHUNK +: CHUNK]};
      end
      for (int j = 0; j < MUL_NB; j++) begin
         if (j == MUL_NB - 1) bch[j] = {b[MB_W-1], b[j*CHUNK +: CHUNK]};
         else                 bch[j] = {1'b0, b[j*CHUNK +: CHUNK]};
      end
      for (int i = 0; i < MUL_NA; i++) begin
         for (int j = 0; j < MUL_NB; j++) begin
            pp_in[i][j] = PP_W'(ach[i]) * PP_W'(bch[j]);
         end
      end
   end

   // two half sums of shifted partial products
   always_comb begin
      lo_in = '0;
      hi_in = '0;
      for (int i = 0; i < MUL_NA; i++) begin
         for (int j = 0; j < MUL_NB; j++) begin
            if (i < MUL_NA / 2) lo_in = lo_in + (MP_W'(pp_ff[i][j]) <<< (CHUNK * (i + j)));
            else                hi_in = hi_in + (MP_W'(pp_ff[i][j]) <<< (CHUNK * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff <= pp_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         p_ff  <= lo_ff + hi_ff;
      end
   end

   assign p = p_ff;

endmodule

@@ rtl/core/ptd_div.sv @@
// ----------------------------------------------------------------------------
// ptd_div: pipelined restoring divider
// One quotient bit per stage, QW stages; numerator below den * 2^QW.
// ----------------------------------------------------------------------------
module ptd_div import ptd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  region_type        in_region,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [RW-1:0]     in_den,
   output logic              out_valid,
   output region_type        out_region,
   output logic [QW-1:0]     out_quot
);

   logic             valid_ff  [QW];
   region_type       region_ff [QW];
   logic [RW-1:0]    rem_ff    [QW];
   logic [RW-1:0]    den_ff    [QW];
   logic [QW-1:0]    bits_ff   [QW];
   logic [QW-1:0]    quot_ff   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          vp;
      region_type    rp;
      logic [RW-1:0] remp, denp, sh;
      logic [QW-1:0] bitsp, quotp;
      logic [RW:0]   trial;

      if (k == 0) begin : g_first
         assign vp    = in_valid;
         assign rp    = in_region;
         assign remp  = in_num[NUM_W-1:QW];
         assign bitsp = in_num[QW-1:0];
         assign denp  = in_den;
         assign quotp = '0;
      end else begin : g_next
         assign vp    = valid_ff[k-1];
         assign rp    = region_ff[k-1];
         assign remp  = rem_ff[k-1];
         assign bitsp = bits_ff[k-1];
         assign denp  = den_ff[k-1];
         assign quotp = quot_ff[k-1];
      end

      // shift in next numerator bit, trial subtract
      assign sh    = {remp[RW-2:0], bitsp[QW-1]};
      assign trial = {1'b0, sh} - {1'b0, denp};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            region_ff[k] <= rp;
            den_ff[k]    <= denp;
            bits_ff[k]   <= {bitsp[QW-2:0], 1'b0};
            rem_ff[k]    <= trial[RW] ? sh : trial[RW-1:0];
            quot_ff[k]   <= {quotp[QW-2:0], ~trial[RW]};
         end
      end
   end

   assign out_valid  = valid_ff[QW-1];
   assign out_region = region_ff[QW-1];
   assign out_quot   = quot_ff[QW-1];

endmodule

@@ rtl/core/ptd_sqrt.sv @@
// ----------------------------------------------------------------------------
// ptd_sqrt: pipelined integer square root
// Digit-by-digit, one root bit per stage, ROOT_W stages; floor result.
// ----------------------------------------------------------------------------
module ptd_sqrt import ptd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  region_type        in_region,
   input  logic [QW-1:0]     in_rad,
   output logic              out_valid,
   output region_type        out_region,
   output logic [ROOT_W-1:0] out_root
);

   logic              valid_ff  [ROOT_W];
   region_type        region_ff [ROOT_W];
   logic [SR_W-1:0]   rem_ff    [ROOT_W];
   logic [ROOT_W-1:0] root_ff   [ROOT_W];
   logic [QW-1:0]     rad_ff    [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              vp, ge;
      region_type        rp;
      logic [SR_W-1:0]   remp, sh, trial;
      logic [ROOT_W-1:0] rootp;
      logic [QW-1:0]     radp;

      if (k == 0) begin : g_first
         assign vp    = in_valid;
         assign rp    = in_region;
         assign remp  = '0;
         assign rootp = '0;
         assign radp  = in_rad;
      end else begin : g_next
         assign vp    = valid_ff[k-1];
         assign rp    = region_ff[k-1];
         assign remp  = rem_ff[k-1];
         assign rootp = root_ff[k-1];
         assign radp  = rad_ff[k-1];
      end

      // bring down two radicand bits, try root*4+1
      assign sh    = {remp[SR_W-3:0], radp[QW-1 -: 2]};
      assign trial = SR_W'({rootp, 2'b01});
      assign ge    = (sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            region_ff[k] <= rp;
            rem_ff[k]    <= ge ? sh - trial : sh;
            root_ff[k]   <= {rootp[ROOT_W-2:0], ge};
            rad_ff[k]    <= {radp[QW-3:0], 2'b00};
         end
      end
   end

   assign out_valid  = valid_ff[ROOT_W-1];
   assign out_region = region_ff[ROOT_W-1];
   assign out_root   = root_ff[ROOT_W-1];

endmodule

@@ rtl/core/point_triangle_distance.sv @@
// ----------------------------------------------------------------------------
// point_triangle_distance: distance from a query point to a fixed triangle
// Voronoi-region closest-point test, exact integer math, floor of distance.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_we/csr_index/csr_wdata load the three corners (index 0..2), each
//    packed as x, y, z of 20 bits from the low end. Other indexes are ignored.
//    Write corners only while no request is in flight.
//  - req_bus carries one query point per request; rsp_bus returns the
//    distance (10 fraction bits, same scale as coordinates) and the region
//    code of the nearest feature (corner, edge, face or degenerate).
//  - Throughput is one request per cycle while rsp_bus is not stalled. A
//    request passes 14 front stages (dot products, two wide multiplier
//    passes, region select), a 42-stage divider for the squared distance
//    and a 21-stage square root before rsp_bus.valid.
//  - The pipeline advances as one unit: when rsp_bus holds a response that
//    is not taken, every stage holds and req_bus.ready drops; nothing is lost.
//  - Reset clears the corners to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module point_triangle_distance import ptd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   ptd_req_if.sink              req_bus,
   ptd_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic adv;

   // configuration and edge vectors
   logic [CSR_W-1:0]           corner_ff [NUM_CORNERS];
   logic signed [CW-1:0]       crn [NUM_CORNERS][3];
   logic signed [DIF_W-1:0]    ab_ff [3];
   logic signed [DIF_W-1:0]    ac_ff [3];

   // front pipeline
   logic signed [CW-1:0]       pt [3];
   logic signed [DIF_W-1:0]    ap_in [3], bp_in [3], cp_in [3];
   logic signed [DIF_W-1:0]    ap_ff [3], bp_ff [3], cp_ff [3];
   logic signed [DIF_W-1:0]    lhs [NDOT][3], rhs [NDOT][3];
   logic signed [PROD_W-1:0]   pr_in [NDOT][3], pr_ff [NDOT][3];
   logic signed [DOT_W-1:0]    dot_in [NDOT], s3_dot_ff [NDOT];
   logic signed [DOT_W-1:0]    x_dot_ff [MUL_LAT][NDOT];
   logic signed [MA_W-1:0]     vma [6];
   logic signed [MB_W-1:0]     vmb [6];
   logic signed [MP_W-1:0]     vmp [6];
   logic signed [MA_W-1:0]     vv_in [3], s7_v_ff [3], s8_v_ff [3];
   logic signed [DOT_W-1:0]    s7_dot_ff [NDOT], s8_dot_ff [NDOT];
   logic signed [MA_W-1:0]     fden_in, fden_ff;
   logic signed [EW-1:0]       e_ff, f_ff;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff;
   logic s13_valid_ff, s14_valid_ff;
   logic x_valid_ff [MUL_LAT];
   logic w_valid_ff [MUL_LAT];

   // region select
   logic signed [DOT_W-1:0]    d1, d2, d3, d4, d5, d6, ap2, bp2, cp2;
   logic signed [MA_W-1:0]     va, vb, vc;
   logic signed [EW-1:0]       den3, den4;
   logic signed [E2W-1:0]      den5;
   region_type                 s9_region_in, s9_region_ff;
   logic                       s9_direct_in, s9_direct_ff;
   logic signed [DOT_W-1:0]    s9_dval_in, s9_dval_ff;
   logic signed [MA_W-1:0]     s9_den_in, s9_den_ff;
   logic signed [MA_W-1:0]     ma_in [3], ma_ff [3];
   logic signed [MB_W-1:0]     mb_in [3], mb_ff [3];
   logic signed [MP_W-1:0]     nmp [3];

   // numerator delay line and back end
   region_type                 w_region_ff [MUL_LAT];
   logic                       w_direct_ff [MUL_LAT];
   logic signed [DOT_W-1:0]    w_dval_ff [MUL_LAT];
   logic signed [MA_W-1:0]     w_den_ff [MUL_LAT];
   logic signed [MP_W-1:0]     s13_num_ff;
   region_type                 s13_region_ff, s14_region_ff;
   logic                       s13_direct_ff;
   logic signed [DOT_W-1:0]    s13_dval_ff;
   logic signed [MA_W-1:0]     s13_den_ff;
   logic [NUM_W-1:0]           s14_num_in, s14_num_ff;
   logic [RW-1:0]              s14_den_in, s14_den_ff;
   logic                       dv_valid;
   region_type                 dv_region, sq_region;
   logic [QW-1:0]              dv_quot;
   logic [ROOT_W-1:0]          sq_root;

   // one stall signal for the whole pipeline
   assign adv           = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = adv;

   // corner registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CORNERS; c++) corner_ff[c] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CORNER_ONE:   corner_ff[0] <= csr_wdata;
            CSR_CORNER_TWO:   corner_ff[1] <= csr_wdata;
            CSR_CORNER_THREE: corner_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         for (int k = 0; k < 3; k++) crn[c][k] = corner_ff[c][k*CW +: CW];
      end
   end

   // edge vectors follow the corners in the next cycle
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         ab_ff[k] <= DIF_W'(crn[1][k]) - DIF_W'(crn[0][k]);
         ac_ff[k] <= DIF_W'(crn[2][k]) - DIF_W'(crn[0][k]);
      end
   end

   // stage 1: point minus corners
   assign pt[0] = req_bus.query_x;
   assign pt[1] = req_bus.query_y;
   assign pt[2] = req_bus.query_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ap_in[k] = DIF_W'(pt[k]) - DIF_W'(crn[0][k]);
         bp_in[k] = DIF_W'(pt[k]) - DIF_W'(crn[1][k]);
         cp_in[k] = DIF_W'(pt[k]) - DIF_W'(crn[2][k]);
      end
   end

   // stage 2: coordinate products (d1..d6, then |ap|^2, |bp|^2, |cp|^2)
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lhs[0][k] = ab_ff[k]; rhs[0][k] = ap_ff[k];
         lhs[1][k] = ac_ff[k]; rhs[1][k] = ap_ff[k];
         lhs[2][k] = ab_ff[k]; rhs[2][k] = bp_ff[k];
         lhs[3][k] = ac_ff[k]; rhs[3][k] = bp_ff[k];
         lhs[4][k] = ab_ff[k]; rhs[4][k] = cp_ff[k];
         lhs[5][k] = ac_ff[k]; rhs[5][k] = cp_ff[k];
         lhs[6][k] = ap_ff[k]; rhs[6][k] = ap_ff[k];
         lhs[7][k] = bp_ff[k]; rhs[7][k] = bp_ff[k];
         lhs[8][k] = cp_ff[k]; rhs[8][k] = cp_ff[k];
      end
      for (int i = 0; i < NDOT; i++) begin
         for (int k = 0; k < 3; k++) pr_in[i][k] = PROD_W'(lhs[i][k]) * PROD_W'(rhs[i][k]);
      end
   end

   // stage 3: dot product sums
   always_comb begin
      for (int i = 0; i < NDOT; i++) begin
         dot_in[i] = DOT_W'(pr_ff[i][0]) + DOT_W'(pr_ff[i][1]) + DOT_W'(pr_ff[i][2]);
      end
   end

   // stages 4-6: barycentric cross terms
   always_comb begin
      vma[0] = MA_W'(s3_dot_ff[0]); vmb[0] = MB_W'(s3_dot_ff[3]);   // d1*d4
      vma[1] = MA_W'(s3_dot_ff[2]); vmb[1] = MB_W'(s3_dot_ff[1]);   // d3*d2
      vma[2] = MA_W'(s3_dot_ff[4]); vmb[2] = MB_W'(s3_dot_ff[1]);   // d5*d2
      vma[3] = MA_W'(s3_dot_ff[0]); vmb[3] = MB_W'(s3_dot_ff[5]);   // d1*d6
      vma[4] = MA_W'(s3_dot_ff[2]); vmb[4] = MB_W'(s3_dot_ff[5]);   // d3*d6
      vma[5] = MA_W'(s3_dot_ff[4]); vmb[5] = MB_W'(s3_dot_ff[3]);   // d5*d4
   end

   for (genvar g = 0; g < 6; g++) begin : g_vmul
      ptd_mul u_mul (
         .clock (clock),
         .adv   (adv),
         .a     (vma[g]),
         .b     (vmb[g]),
         .p     (vmp[g])
      );
   end

   // stage 7: vc, vb, va
   assign vv_in[0] = MA_W'(vmp[0] - vmp[1]);
   assign vv_in[1] = MA_W'(vmp[2] - vmp[3]);
   assign vv_in[2] = MA_W'(vmp[4] - vmp[5]);

   // stage 8: face denominator
   assign fden_in = s7_v_ff[0] + s7_v_ff[1] + s7_v_ff[2];

   // stage 9: region select
   assign d1  = s8_dot_ff[0];
   assign d2  = s8_dot_ff[1];
   assign d3  = s8_dot_ff[2];
   assign d4  = s8_dot_ff[3];
   assign d5  = s8_dot_ff[4];
   assign d6  = s8_dot_ff[5];
   assign ap2 = s8_dot_ff[6];
   assign bp2 = s8_dot_ff[7];
   assign cp2 = s8_dot_ff[8];
   assign vc  = s8_v_ff[0];
   assign vb  = s8_v_ff[1];
   assign va  = s8_v_ff[2];
   assign den3 = EW'(d1) - EW'(d3);
   assign den4 = EW'(d2) - EW'(d6);
   assign den5 = E2W'(e_ff) + E2W'(f_ff);

   always_comb begin
      s9_region_in = RGN_DEGEN;
      s9_direct_in = 1'b1;
      s9_dval_in   = ap2;
      s9_den_in    = MA_W'(1);
      for (int m = 0; m < 3; m++) begin
         ma_in[m] = '0;
         mb_in[m] = '0;
      end
      if (d1 <= 0 && d2 <= 0) begin
         s9_region_in = RGN_CORNER_A;
      end else if (d3 >= 0 && d4 <= d3) begin
         s9_region_in = RGN_CORNER_B;
         s9_dval_in   = bp2;
      end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
         if (den3 > 0) begin
            s9_region_in = RGN_EDGE_AB;
            s9_direct_in = 1'b0;
            s9_den_in    = MA_W'(den3);
            ma_in[0]     = MA_W'(den3);
            mb_in[0]     = MB_W'(ap2);
            ma_in[1]     = MA_W'(d1);
            mb_in[1]     = MB_W'(d1);
         end
      end else if (d6 >= 0 && d5 <= d6) begin
         s9_region_in = RGN_CORNER_C;
         s9_dval_in   = cp2;
      end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
         if (den4 > 0) begin
            s9_region_in = RGN_EDGE_AC;
            s9_direct_in = 1'b0;
            s9_den_in    = MA_W'(den4);
            ma_in[0]     = MA_W'(den4);
            mb_in[0]     = MB_W'(ap2);
            ma_in[1]     = MA_W'(d2);
            mb_in[1]     = MB_W'(d2);
         end
      end else if (va <= 0 && e_ff >= 0 && f_ff >= 0) begin
         if (den5 > 0) begin
            s9_region_in = RGN_EDGE_BC;
            s9_direct_in = 1'b0;
            s9_den_in    = MA_W'(den5);
            ma_in[0]     = MA_W'(den5);
            mb_in[0]     = MB_W'(bp2);
            ma_in[1]     = MA_W'(e_ff);
            mb_in[1]     = MB_W'(e_ff);
         end
      end else begin
         if (fden_ff > 0) begin
            s9_region_in = RGN_FACE;
            s9_direct_in = 1'b0;
            s9_den_in    = fden_ff;
            ma_in[0]     = fden_ff;
            mb_in[0]     = MB_W'(ap2);
            ma_in[1]     = vb;
            mb_in[1]     = MB_W'(d1);
            ma_in[2]     = vc;
            mb_in[2]     = MB_W'(d2);
         end
      end
   end

   // stages 10-12: numerator products
   for (genvar g = 0; g < 3; g++) begin : g_nmul
      ptd_mul u_mul (
         .clock (clock),
         .adv   (adv),
         .a     (ma_ff[g]),
         .b     (mb_ff[g]),
         .p     (nmp[g])
      );
   end

   // stage 14: numerator/denominator for the divider
   always_comb begin
      if (s13_direct_ff) begin
         s14_num_in = NUM_W'($unsigned(s13_dval_ff));
         s14_den_in = RW'(1);
      end else if (s13_num_ff <= 0) begin
         s14_num_in = '0;
         s14_den_in = $unsigned(s13_den_ff);
      end else begin
         s14_num_in = s13_num_ff[NUM_W-1:0];
         s14_den_in = $unsigned(s13_den_ff);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s13_valid_ff <= 1'b0;
         s14_valid_ff <= 1'b0;
         for (int s = 0; s < MUL_LAT; s++) begin
            x_valid_ff[s] <= 1'b0;
            w_valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         s1_valid_ff   <= req_bus.valid;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         x_valid_ff[0] <= s3_valid_ff;
         for (int s = 1; s < MUL_LAT; s++) x_valid_ff[s] <= x_valid_ff[s-1];
         s7_valid_ff   <= x_valid_ff[MUL_LAT-1];
         s8_valid_ff   <= s7_valid_ff;
         s9_valid_ff   <= s8_valid_ff;
         w_valid_ff[0] <= s9_valid_ff;
         for (int s = 1; s < MUL_LAT; s++) w_valid_ff[s] <= w_valid_ff[s-1];
         s13_valid_ff  <= w_valid_ff[MUL_LAT-1];
         s14_valid_ff  <= s13_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         ap_ff       <= ap_in;
         bp_ff       <= bp_in;
         cp_ff       <= cp_in;
         pr_ff       <= pr_in;
         s3_dot_ff   <= dot_in;
         x_dot_ff[0] <= s3_dot_ff;
         for (int s = 1; s < MUL_LAT; s++) x_dot_ff[s] <= x_dot_ff[s-1];
         s7_v_ff     <= vv_in;
         s7_dot_ff   <= x_dot_ff[MUL_LAT-1];
         s8_v_ff     <= s7_v_ff;
         s8_dot_ff   <= s7_dot_ff;
         fden_ff     <= fden_in;
         e_ff        <= EW'(s7_dot_ff[3]) - EW'(s7_dot_ff[2]);
         f_ff        <= EW'(s7_dot_ff[4]) - EW'(s7_dot_ff[5]);
         s9_region_ff <= s9_region_in;
         s9_direct_ff <= s9_direct_in;
         s9_dval_ff   <= s9_dval_in;
         s9_den_ff    <= s9_den_in;
         ma_ff        <= ma_in;
         mb_ff        <= mb_in;
         w_region_ff[0] <= s9_region_ff;
         w_direct_ff[0] <= s9_direct_ff;
         w_dval_ff[0]   <= s9_dval_ff;
         w_den_ff[0]    <= s9_den_ff;
         for (int s = 1; s < MUL_LAT; s++) begin
            w_region_ff[s] <= w_region_ff[s-1];
            w_direct_ff[s] <= w_direct_ff[s-1];
            w_dval_ff[s]   <= w_dval_ff[s-1];
            w_den_ff[s]    <= w_den_ff[s-1];
         end
         s13_num_ff    <= nmp[0] - nmp[1] - nmp[2];
         s13_region_ff <= w_region_ff[MUL_LAT-1];
         s13_direct_ff <= w_direct_ff[MUL_LAT-1];
         s13_dval_ff   <= w_dval_ff[MUL_LAT-1];
         s13_den_ff    <= w_den_ff[MUL_LAT-1];
         s14_num_ff    <= s14_num_in;
         s14_den_ff    <= s14_den_in;
         s14_region_ff <= s13_region_ff;
      end
   end

   // squared distance, then root
   ptd_div u_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (s14_valid_ff),
      .in_region  (s14_region_ff),
      .in_num     (s14_num_ff),
      .in_den     (s14_den_ff),
      .out_valid  (dv_valid),
      .out_region (dv_region),
      .out_quot   (dv_quot)
   );

   ptd_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (dv_valid),
      .in_region  (dv_region),
      .in_rad     (dv_quot),
      .out_valid  (rsp_bus.valid),
      .out_region (sq_region),
      .out_root   (sq_root)
   );

   // root of a 42-bit value always fits the distance field
   assign rsp_bus.distance       = sq_root;
   assign rsp_bus.nearest_region = sq_region;

endmodule

@@ rtl/core/ptd_checker.sv @@
// ----------------------------------------------------------------------------
// ptd_checker: port-level checks of the point-triangle distance unit
// Stall behavior of the response channel and reset of the pipeline.
// ----------------------------------------------------------------------------
module ptd_checker import ptd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DIST_W-1:0] rsp_distance,
   input logic [2:0]        rsp_region
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_distance) && $stable(rsp_region))
      else $error("response payload changed while stalled");

   // requests are taken exactly when the pipeline can advance
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output stall");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind point_triangle_distance ptd_checker u_ptd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_distance (rsp_bus.distance),
   .rsp_region   (rsp_bus.nearest_region)
);

@@ test/ptd_checker.sv @@
// ----------------------------------------------------------------------------
// ptd_scoreboard: response checker of the point-triangle distance unit
// Tracks corner writes, predicts distance and region of every accepted
// request with exact wide integer math, and compares the responses in order.
// ----------------------------------------------------------------------------
module ptd_scoreboard import ptd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   ptd_req_if                   req_bus,
   ptd_rsp_if                   rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   mismatches,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [191:0] wide_t;
   typedef longint vec_t [3];

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      region_type        region;
   } answer_t;

   logic [CSR_W-1:0] corner_regs [NUM_CORNERS];
   answer_t          answer_queue [$];

   function automatic longint dot(vec_t u, vec_t v);
      return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, bit_val;
      r = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > x) bit_val >>= 2;
      while (bit_val != 0) begin
         if (x >= r + bit_val) begin
            x -= r + bit_val;
            r = (r >> 1) + bit_val;
         end else begin
            r >>= 1;
         end
         bit_val >>= 2;
      end
      return r;
   endfunction

   // squared distance from a numerator over a positive denominator
   function automatic longint unsigned quot(wide_t num, wide_t den);
      wide_t q;
      if (num <= 0) return 0;
      q = num / den;
      return q[63:0];
   endfunction

   function automatic answer_t triangle_distance(logic signed [CW-1:0] qx,
                                                 logic signed [CW-1:0] qy,
                                                 logic signed [CW-1:0] qz);
      vec_t a, b, c, p, ab, ac, ap, bp, cp;
      longint d1, d2, d3, d4, d5, d6, ap2;
      wide_t va, vb, vc, den, num;
      longint unsigned dist2, dist_val;
      region_type rgn;
      answer_t r;
      p[0] = qx; p[1] = qy; p[2] = qz;
      for (int k = 0; k < 3; k++) begin
         a[k] = longint'(signed'(corner_regs[0][k*CW +: CW]));
         b[k] = longint'(signed'(corner_regs[1][k*CW +: CW]));
         c[k] = longint'(signed'(corner_regs[2][k*CW +: CW]));
         ab[k] = b[k] - a[k];
         ac[k] = c[k] - a[k];
         ap[k] = p[k] - a[k];
         bp[k] = p[k] - b[k];
         cp[k] = p[k] - c[k];
      end
      ap2 = dot(ap, ap);
      d1 = dot(ab, ap); d2 = dot(ac, ap);
      d3 = dot(ab, bp); d4 = dot(ac, bp);
      d5 = dot(ab, cp); d6 = dot(ac, cp);
      vc = wide_t'(d1) * wide_t'(d4) - wide_t'(d3) * wide_t'(d2);
      vb = wide_t'(d5) * wide_t'(d2) - wide_t'(d1) * wide_t'(d6);
      va = wide_t'(d3) * wide_t'(d6) - wide_t'(d5) * wide_t'(d4);

      // Voronoi regions: corners, edges by projection, then the face
      if (d1 <= 0 && d2 <= 0) begin
         rgn = RGN_CORNER_A; dist2 = ap2;
      end else if (d3 >= 0 && d4 <= d3) begin
         rgn = RGN_CORNER_B; dist2 = dot(bp, bp);
      end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
         den = wide_t'(d1 - d3);
         if (den <= 0) begin
            rgn = RGN_DEGEN; dist2 = ap2;
         end else begin
            num = wide_t'(ap2) * den - wide_t'(d1) * wide_t'(d1);
            rgn = RGN_EDGE_AB; dist2 = quot(num, den);
         end
      end else if (d6 >= 0 && d5 <= d6) begin
         rgn = RGN_CORNER_C; dist2 = dot(cp, cp);
      end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
         den = wide_t'(d2 - d6);
         if (den <= 0) begin
            rgn = RGN_DEGEN; dist2 = ap2;
         end else begin
            num = wide_t'(ap2) * den - wide_t'(d2) * wide_t'(d2);
            rgn = RGN_EDGE_AC; dist2 = quot(num, den);
         end
      end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
         den = wide_t'((d4 - d3) + (d5 - d6));
         if (den <= 0) begin
            rgn = RGN_DEGEN; dist2 = ap2;
         end else begin
            num = wide_t'(dot(bp, bp)) * den - wide_t'(d4 - d3) * wide_t'(d4 - d3);
            rgn = RGN_EDGE_BC; dist2 = quot(num, den);
         end
      end else begin
         den = va + vb + vc;
         if (den <= 0) begin
            rgn = RGN_DEGEN; dist2 = ap2;
         end else begin
            num = wide_t'(ap2) * den - vb * wide_t'(d1) - vc * wide_t'(d2);
            rgn = RGN_FACE; dist2 = quot(num, den);
         end
      end

      dist_val = int_sqrt(dist2);
      if (dist_val > 2097151) dist_val = 2097151;
      r.distance = dist_val[DIST_W-1:0];
      r.region   = rgn;
      return r;
   endfunction

   // corner shadow, request prediction and response compare
   always @(posedge clock) begin
      answer_t want;
      if (reset) begin
         for (int i = 0; i < NUM_CORNERS; i++) corner_regs[i] <= '0;
         answer_queue.delete();
         mismatches <= 0;
      end else begin
         if (csr_we && csr_index < NUM_CORNERS) corner_regs[csr_index] <= csr_wdata;
         if (req_bus.valid && req_bus.ready)
            answer_queue.push_back(triangle_distance(req_bus.query_x,
                                                     req_bus.query_y,
                                                     req_bus.query_z));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answer_queue.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected response: distance %0d region %0d",
                           rsp_bus.distance, rsp_bus.nearest_region);
               mismatches <= mismatches + 1;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_bus.distance !== want.distance ||
                   rsp_bus.nearest_region !== want.region) begin
                  if (mismatches < 10)
                     $display("mismatch: expected distance %0d region %0d, got %0d region %0d",
                              want.distance, want.region,
                              rsp_bus.distance, rsp_bus.nearest_region);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
      pending = answer_queue.size();
   end
endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: point-triangle distance unit
// Loads a series of triangles (zero, regular, extreme, collinear, coincident
// corners, random) and streams directed and random query points through the
// unit with random stalls on both channels; ptd_scoreboard does the comparison.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ptd_pkg::*;

   localparam int CMAX = 524287;
   localparam int CMIN = -524288;
   localparam int STALL_LIMIT = 20000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 quiet = 1'b0;
   int                   mismatches, pending;
   int                   requests_sent = 0, triangles = 1, idle_cycles = 0;
   int                   tri_pts [3][3];

   ptd_req_if req_bus ();
   ptd_rsp_if rsp_bus ();

   point_triangle_distance u_dut (
      .clock, .reset, .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_we, .csr_index, .csr_wdata
   );

   ptd_scoreboard u_checker (
      .clock, .reset, .req_bus, .rsp_bus, .csr_we, .csr_index, .csr_wdata,
      .mismatches, .pending
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.query_x = '0;
      req_bus.query_y = '0;
      req_bus.query_z = '0;
      rsp_bus.ready = 1'b0;
   end

   // response back-pressure
   always @(negedge clock) rsp_bus.ready <= quiet || ($urandom_range(99) >= 36);

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int clamp(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return int'(v);
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(3))
         0: return clamp(longint'($urandom_range(1048575)) - 524288);
         1: return $urandom_range(4095) - 2048;
         2: return $urandom_range(1) ? CMAX : CMIN;
         default: return $urandom_range(200000) - 100000;
      endcase
   endfunction

   // one query request, entered and left at a falling edge
   task automatic send_query(int qx, int qy, int qz);
      while (!quiet && $urandom_range(99) < 36) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.query_x <= qx[CW-1:0];
      req_bus.query_y <= qy[CW-1:0];
      req_bus.query_z <= qz[CW-1:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic write_corner(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // drain the pipe, then load a new triangle
   task automatic load_triangle(int pts [3][3]);
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (90) @(negedge clock);
      for (int i = 0; i < 3; i++) begin
         write_corner(i[CSR_IDX_W-1:0], {pts[i][2][CW-1:0], pts[i][1][CW-1:0],
                                          pts[i][0][CW-1:0]});
         @(negedge clock);
      end
      tri_pts = pts;
      triangles++;
   endtask

   // corners, edge midpoints raised by 777 in z, centroid, extremes of the coordinates, 0 and -1
   task automatic directed_queries();
      for (int i = 0; i < 3; i++)
         send_query(tri_pts[i][0], tri_pts[i][1], tri_pts[i][2]);
      for (int i = 0; i < 3; i++)
         send_query(clamp((longint'(tri_pts[i][0]) + tri_pts[(i+1)%3][0]) / 2),
                    clamp((longint'(tri_pts[i][1]) + tri_pts[(i+1)%3][1]) / 2),
                    clamp((longint'(tri_pts[i][2]) + tri_pts[(i+1)%3][2]) / 2) + 777);
      send_query(clamp((longint'(tri_pts[0][0]) + tri_pts[1][0] + tri_pts[2][0]) / 3),
                 clamp((longint'(tri_pts[0][1]) + tri_pts[1][1] + tri_pts[2][1]) / 3),
                 clamp((longint'(tri_pts[0][2]) + tri_pts[1][2] + tri_pts[2][2]) / 3));
      send_query(CMIN, CMIN, CMIN);
      send_query(CMAX, CMAX, CMAX);
      send_query(CMAX, CMIN, CMAX);
      send_query(CMIN, CMAX, CMIN);
      send_query(0, 0, 0);
      send_query(-1, -1, -1);
   endtask

   // random points, mostly near the triangle, some anywhere
   task automatic random_queries(int count);
      longint w0, w1, w2, s;
      int pt [3];
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 30) begin
            send_query(rand_coord(), rand_coord(), rand_coord());
         end else begin
            w0 = $urandom_range(1000); w1 = $urandom_range(1000);
            w2 = $urandom_range(1000); s = w0 + w1 + w2 + 1;
            for (int k = 0; k < 3; k++)
               pt[k] = clamp((w0 * tri_pts[0][k] + w1 * tri_pts[1][k]
                              + w2 * tri_pts[2][k]) / s
                             + longint'($urandom_range(8191)) - 4096);
            send_query(pt[0], pt[1], pt[2]);
         end
      end
   endtask

   initial begin
      int pts [3][3];
      tri_pts = '{default: 0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corners still at reset: everything coincident
      directed_queries();
      random_queries(150);

      // regular triangle
      pts = '{'{0, 0, 0}, '{20480, 0, 0}, '{0, 20480, 5120}};
      load_triangle(pts);
      directed_queries();
      random_queries(220);

      // extreme corners, then a write to the unused index on the drained pipe
      pts = '{'{CMIN, CMIN, CMIN}, '{CMAX, CMAX, CMAX}, '{CMAX, CMIN, 0}};
      load_triangle(pts);
      write_corner(2'd3, '1);
      directed_queries();
      quiet <= 1'b1;
      random_queries(220);
      quiet <= 1'b0;

      // collinear corners: zero face area
      pts = '{'{-3000, -3000, 100}, '{0, 0, 100}, '{6000, 6000, 100}};
      load_triangle(pts);
      directed_queries();
      random_queries(200);

      // first two corners coincide: zero edge length
      pts = '{'{4000, -2000, 900}, '{4000, -2000, 900}, '{-7000, 5000, -300}};
      load_triangle(pts);
      directed_queries();
      random_queries(200);

      // random triangles
      for (int t = 0; t < 3; t++) begin
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) pts[i][k] = rand_coord();
         load_triangle(pts);
         directed_queries();
         random_queries(180);
      end

      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("ran %0d query points against %0d triangle settings", requests_sent,
               triangles);
      $display("settings covered zero, extreme, collinear, coincident and random corners");
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/ptd_pkg.sv
rtl/core/ptd_if.sv
rtl/core/ptd_mul.sv
rtl/core/ptd_div.sv
rtl/core/ptd_sqrt.sv
rtl/core/point_triangle_distance.sv
rtl/core/ptd_checker.sv
test/ptd_checker.sv
test/testbench.sv
